// ----- rtl/slbcp_pkg.sv -----
// shared types, codes and constants for the serial led/switch/buzzer command parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package slbcp_pkg;

	// ascii characters of the command set
	localparam logic [7:0] CH_L    = 8'h4C;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_FOUR = 8'h34;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// digit weights of the buzzer time
	localparam logic [9:0] BUZ_HUNDREDS = 10'd100;
	localparam logic [9:0] BUZ_TENS     = 10'd10;

	// parse state
	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_LED     = 4'd1,
		ST_LSET    = 4'd2,
		ST_LCLR    = 4'd3,
		ST_LREAD   = 4'd4,
		ST_SWITCH  = 4'd5,
		ST_BUZ     = 4'd6,
		ST_BUZ_X00 = 4'd7,
		ST_BUZ_XX0 = 4'd8
	} state_t;

	// result event codes
	typedef enum logic [1:0] {
		EV_ACK   = 2'd0,
		EV_ERR   = 2'd1,
		EV_CLOSE = 2'd2,
		EV_OPEN  = 2'd3
	} event_t;

	// one result item
	typedef struct packed {
		event_t     ev;
		logic       last;
		logic [3:0] leds;
		logic [9:0] buzzer;
		logic       loaded;
	} result_t;

	// all results caused by one received byte
	typedef struct packed {
		logic [1:0] cnt;
		result_t    res0;
		result_t    res1;
	} step_t;

	function automatic result_t mk_result(event_t ev, logic last, logic [3:0] leds,
			logic [9:0] buzzer, logic loaded);
		result_t r;
		r.ev     = ev;
		r.last   = last;
		r.leds   = leds;
		r.buzzer = buzzer;
		r.loaded = loaded;
		return r;
	endfunction

endpackage

// ----- rtl/slbcp_parser.sv -----
// command parser: parse state, led mask and buzzer registers, plus result decode
// depends on slbcp_pkg
`timescale 1ns / 1ps

module slbcp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [7:0]         rx_byte,
	input  logic [3:0]         switch_levels,
	output slbcp_pkg::step_t   step
);
	import slbcp_pkg::*;

	state_t     state_q, state_d;
	logic [3:0] led_q, led_d;
	logic [9:0] part_q, part_d;
	logic [9:0] buz_q, buz_d;

	logic       sel_ok, dig_ok;
	logic [3:0] sel_bit;
	logic [3:0] dig;
	logic       err, done_one, loaded, read_pair, reply_on;

	// character classes
	always_comb begin
		sel_ok  = (rx_byte >= CH_ONE) && (rx_byte <= CH_FOUR);
		dig_ok  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
		sel_bit = sel_ok ? (4'b0001 << rx_byte[1:0] - 2'd1) : 4'b0000;
		dig     = dig_ok ? rx_byte[3:0] : 4'd0;
	end

	// next parse state
	always_comb begin
		state_d = ST_IDLE;
		unique case (state_q)
			ST_LED: begin
				if (rx_byte == CH_S)
					state_d = ST_LSET;
				else if (rx_byte == CH_C)
					state_d = ST_LCLR;
				else if (rx_byte == CH_R)
					state_d = ST_LREAD;
			end
			ST_BUZ: begin
				if (dig_ok)
					state_d = ST_BUZ_X00;
			end
			ST_BUZ_X00: begin
				if (dig_ok)
					state_d = ST_BUZ_XX0;
			end
			ST_LSET, ST_LCLR, ST_LREAD, ST_SWITCH, ST_BUZ_XX0: begin
				state_d = ST_IDLE;
			end
			default: begin
				if (rx_byte == CH_L)
					state_d = ST_LED;
				else if (rx_byte == CH_S)
					state_d = ST_SWITCH;
				else if (rx_byte == CH_B)
					state_d = ST_BUZ;
			end
		endcase
	end

	// datapath updates and result classification
	always_comb begin
		err       = 1'b0;
		done_one  = 1'b0;
		loaded    = 1'b0;
		read_pair = 1'b0;
		reply_on  = 1'b0;
		led_d     = led_q;
		part_d    = part_q;
		buz_d     = buz_q;
		unique case (state_q)
			ST_LED: begin
				err = !((rx_byte == CH_S) || (rx_byte == CH_C) || (rx_byte == CH_R));
			end
			ST_LSET: begin
				if (sel_ok) begin
					led_d    = led_q | sel_bit;
					done_one = 1'b1;
				end else
					err = 1'b1;
			end
			ST_LCLR: begin
				if (sel_ok) begin
					led_d    = led_q & ~sel_bit;
					done_one = 1'b1;
				end else
					err = 1'b1;
			end
			ST_LREAD: begin
				if (sel_ok) begin
					read_pair = 1'b1;
					reply_on  = |(led_q & sel_bit);
				end else
					err = 1'b1;
			end
			ST_SWITCH: begin
				if (sel_ok) begin
					read_pair = 1'b1;
					reply_on  = |(switch_levels & sel_bit);
				end else
					err = 1'b1;
			end
			ST_BUZ: begin
				if (dig_ok)
					part_d = 10'(BUZ_HUNDREDS * {6'd0, dig});
				else
					err = 1'b1;
			end
			ST_BUZ_X00: begin
				if (dig_ok)
					part_d = 10'(part_q + BUZ_TENS * {6'd0, dig});
				else
					err = 1'b1;
			end
			ST_BUZ_XX0: begin
				if (dig_ok) begin
					part_d   = 10'(part_q + {6'd0, dig});
					buz_d    = part_d;
					done_one = 1'b1;
					loaded   = 1'b1;
				end else
					err = 1'b1;
			end
			default: begin
				err = !((rx_byte == CH_L) || (rx_byte == CH_S) || (rx_byte == CH_B));
			end
		endcase
	end

	// result items for this byte
	always_comb begin
		step.cnt  = 2'd0;
		step.res0 = mk_result(EV_ACK, 1'b1, led_d, buz_d, 1'b0);
		step.res1 = mk_result(EV_ACK, 1'b1, led_d, buz_d, 1'b0);
		if (read_pair) begin
			step.cnt  = 2'd2;
			step.res0 = mk_result(EV_ACK, 1'b0, led_d, buz_d, 1'b0);
			step.res1 = mk_result(reply_on ? EV_CLOSE : EV_OPEN, 1'b1, led_d, buz_d, 1'b0);
		end else if (done_one) begin
			step.cnt  = 2'd1;
			step.res0 = mk_result(EV_ACK, 1'b1, led_d, buz_d, loaded);
		end else if (err) begin
			step.cnt  = 2'd1;
			step.res0 = mk_result(EV_ERR, 1'b1, led_d, buz_d, 1'b0);
		end
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			led_q   <= 4'd0;
			part_q  <= 10'd0;
			buz_q   <= 10'd0;
		end else if (go) begin
			state_q <= state_d;
			led_q   <= led_d;
			part_q  <= part_d;
			buz_q   <= buz_d;
		end
	end

endmodule

// ----- rtl/slbcp_res_buf.sv -----
// result register holding the one or two results of a byte and presenting them in order
// depends on slbcp_pkg
`timescale 1ns / 1ps

module slbcp_res_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  slbcp_pkg::step_t   step,
	output logic               free,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_res,
	output logic               last,
	output logic [3:0]         led_states,
	output logic [9:0]         buzzer_ms,
	output logic               buzzer_loaded
);
	import slbcp_pkg::*;

	result_t    res0_q, res1_q;
	logic [1:0] rem_q;
	logic       idx_q;
	result_t    cur;
	logic       pop;

	// head result and handshake
	always_comb begin
		cur           = idx_q ? res1_q : res0_q;
		out_valid     = (rem_q != 2'd0);
		pop           = out_valid && out_ready;
		free          = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_ready);
		event_res     = cur.ev;
		last          = cur.last;
		led_states    = cur.leds;
		buzzer_ms     = cur.buzzer;
		buzzer_loaded = cur.loaded;
	end

	// count and index of pending results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			idx_q <= 1'b0;
		end else if (load) begin
			rem_q <= step.cnt;
			idx_q <= 1'b0;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
			idx_q <= 1'b1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res0_q <= step.res0;
			res1_q <= step.res1;
		end
	end

endmodule

// ----- rtl/serial_led_switch_buzzer_command_parser.sv -----
// top level of the serial led/switch/buzzer command parser
// depends on slbcp_pkg, slbcp_parser and slbcp_res_buf
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready, rx_byte, switch_levels) takes one
// received ASCII byte per request together with the present switch levels.
// The output channel (out_valid/out_ready) returns zero, one or two results
// per byte: ack, error, reply closed or reply open, with the LED mask and the
// buzzer time after that byte; last marks the final result of a byte.
// A byte is captured in an input register; once the result register can take
// its results, the parser consumes it and writes them into the result register,
// from which the first result is presented on the output channel.
// Bytes with zero or one result flow at one per cycle while the receiver
// takes each result; a read command (LR, S) gives two results and holds the
// result register until its second result is taken.
// If the receiver stalls, the pending results are held and the input register
// fills, after which in_ready drops until the results are taken.
// Reset clears the parse state to idle, all LEDs off, buzzer time zero, and
// discards any pending byte or result.

module serial_led_switch_buzzer_command_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic [3:0]  switch_levels,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_res,
	output logic        last,
	output logic [3:0]  led_states,
	output logic [9:0]  buzzer_ms,
	output logic        buzzer_loaded
);
	import slbcp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [3:0] sw_s1;
	step_t      step;
	logic       buf_free;
	logic       adv;
	logic       load;

	// advance of the captured byte into the parser
	always_comb begin
		adv      = valid_s1 && ((step.cnt == 2'd0) || buf_free);
		load     = adv && (step.cnt != 2'd0);
		in_ready = !valid_s1 || adv;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
			sw_s1   <= switch_levels;
		end
	end

	slbcp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (adv),
		.rx_byte       (byte_s1),
		.switch_levels (sw_s1),
		.step          (step)
	);

	slbcp_res_buf u_res_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.step          (step),
		.free          (buf_free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_res     (event_res),
		.last          (last),
		.led_states    (led_states),
		.buzzer_ms     (buzzer_ms),
		.buzzer_loaded (buzzer_loaded)
	);

endmodule
